FILE: hdl/bfbp_pkg.sv
// ----------------------------------------------------------------------------
// bfbp_pkg
// Shared constants for the best-fit bin packer: field widths, status codes
// and reset values.
// ----------------------------------------------------------------------------
package bfbp_pkg;

   // Field widths of the request, response and register beats
   localparam int DURATION_W = 20;
   localparam int CAPACITY_W = 20;
   localparam int LOAD_W     = 21;
   localparam int STATUS_W   = 3;
   localparam int BIN_IDX_W  = 6;
   localparam int BINS_USED_W = 7;

   // Default number of bins
   localparam int MAX_BINS_DEFAULT = 64;

   // Capacity after reset: eighteen hours in seconds
   localparam logic [CAPACITY_W-1:0] CAPACITY_RESET = CAPACITY_W'(18 * 3600);

   // Response status codes
   localparam logic [STATUS_W-1:0] ST_ADDED    = 3'd0;
   localparam logic [STATUS_W-1:0] ST_OPENED   = 3'd1;
   localparam logic [STATUS_W-1:0] ST_UNPLACED = 3'd2;
   localparam logic [STATUS_W-1:0] ST_REJECTED = 3'd3;
   localparam logic [STATUS_W-1:0] ST_CLEARED  = 3'd4;

   // Request command codes
   localparam logic CMD_PLACE = 1'b0;
   localparam logic CMD_CLEAR = 1'b1;

endpackage

FILE: hdl/bfbp_ram.sv
// ----------------------------------------------------------------------------
// bfbp_ram
// Simple dual-port RAM: one write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module bfbp_ram #(
   parameter int WIDTH = 21,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/best_fit_bin_packer_top.sv
// ----------------------------------------------------------------------------
// best_fit_bin_packer_top
// Online best-fit bin packing of jobs by duration, bin loads held in a RAM.
// ----------------------------------------------------------------------------
// Usage:
//   Request: drive req_cmd / req_job_duration and pulse start; the beat is
//   taken on a clock edge where start is high and busy is low. A place
//   command scans the loads of all open bins, one RAM read per cycle, keeps
//   the fullest bin that still stays strictly under the capacity (lowest bin
//   on ties), then writes the new load back or opens a new bin.
//   Response: one beat per request, shown for exactly one cycle with
//   rsp_strobe high; the receiver cannot hold it off. The next request may
//   be taken in the same cycle as the strobe.
//   Sequence: a place command runs S_SCAN, which reads the loads of the open
//   bins over the single RAM read port, so the scan grows with the number of
//   open bins, then S_DECIDE, which writes the load and raises the strobe.
//   A clear answers in the next cycle.
//   Configuration: csr_bin_capacity is written on csr_valid (csr_ready is
//   always high); write it only while the block is idle.
//   Reset: synchronous, active high; all bins closed, capacity 64800 s.
//   The RAM needs no clearing pass: only opened entries are ever read.
// ----------------------------------------------------------------------------
module best_fit_bin_packer_top
   import bfbp_pkg::*;
#(
   parameter int MAX_BINS = MAX_BINS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   // Request channel
   input  logic                   start,
   output logic                   busy,
   input  logic                   req_cmd,
   input  logic [DURATION_W-1:0]  req_job_duration,
   // Response channel
   output logic                   rsp_strobe,
   output logic [STATUS_W-1:0]    rsp_status,
   output logic [BIN_IDX_W-1:0]   rsp_bin_index,
   output logic [LOAD_W-1:0]      rsp_bin_load,
   output logic [BINS_USED_W-1:0] rsp_bins_used,
   // Register write channel
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CAPACITY_W-1:0]  csr_bin_capacity
);

   localparam int IDX_W = $clog2(MAX_BINS);
   localparam int CNT_W = $clog2(MAX_BINS + 1);
   localparam int SUM_W = LOAD_W + 1;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_DECIDE
   } state_type;

   state_type              state_ff, state_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [CNT_W-1:0]       issue_ff, issue_in;
   logic                   chk_vld_ff, chk_vld_in;
   logic [IDX_W-1:0]       chk_idx_ff, chk_idx_in;
   logic                   found_ff, found_in;
   logic [IDX_W-1:0]       best_ff, best_in;
   logic [LOAD_W-1:0]      best_load_ff, best_load_in;
   logic [DURATION_W-1:0]  dur_ff, dur_in;
   logic [CAPACITY_W-1:0]  cap_ff, cap_in;
   logic                   rsp_strobe_ff, rsp_strobe_in;
   logic [STATUS_W-1:0]    rsp_status_ff, rsp_status_in;
   logic [IDX_W-1:0]       rsp_idx_ff, rsp_idx_in;
   logic [LOAD_W-1:0]      rsp_load_ff, rsp_load_in;

   logic                   ram_wr_en;
   logic [IDX_W-1:0]       ram_wr_addr;
   logic [LOAD_W-1:0]      ram_wr_data;
   logic [LOAD_W-1:0]      ram_rd_data;
   logic [SUM_W-1:0]       chk_sum;
   logic                   chk_better;
   logic [LOAD_W-1:0]      added_load;
   logic                   accept;

   // Bin load store
   bfbp_ram #(
      .WIDTH (LOAD_W),
      .DEPTH (MAX_BINS)
   ) u_load_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (issue_ff[IDX_W-1:0]),
      .rd_data (ram_rd_data)
   );

   assign accept    = start && (state_ff == S_IDLE);
   assign busy      = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;

   // Fit test on the load returned by the RAM
   assign chk_sum    = SUM_W'(ram_rd_data) + SUM_W'(dur_ff);
   assign chk_better = (chk_sum < SUM_W'(cap_ff)) &&
                       (!found_ff || (ram_rd_data > best_load_ff));
   assign added_load = best_load_ff + LOAD_W'(dur_ff);

   // Next-state and datapath logic
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      issue_in      = issue_ff;
      chk_vld_in    = 1'b0;
      chk_idx_in    = issue_ff[IDX_W-1:0];
      found_in      = found_ff;
      best_in       = best_ff;
      best_load_in  = best_load_ff;
      dur_in        = dur_ff;
      cap_in        = cap_ff;
      rsp_strobe_in = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_idx_in    = rsp_idx_ff;
      rsp_load_in   = rsp_load_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = best_ff;
      ram_wr_data   = added_load;

      if (csr_valid && csr_ready) begin
         cap_in = csr_bin_capacity;
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_cmd == CMD_CLEAR) begin
                  count_in      = '0;
                  rsp_strobe_in = 1'b1;
                  rsp_status_in = ST_CLEARED;
                  rsp_idx_in    = '0;
                  rsp_load_in   = '0;
               end else begin
                  dur_in   = req_job_duration;
                  issue_in = '0;
                  found_in = 1'b0;
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            // Issue one read per cycle; each compare runs in the cycle after its read
            if (issue_ff != count_ff) begin
               chk_vld_in = 1'b1;
               issue_in   = issue_ff + CNT_W'(1);
            end else begin
               state_in = S_DECIDE;
            end
            if (chk_vld_ff && chk_better) begin
               found_in     = 1'b1;
               best_in      = chk_idx_ff;
               best_load_in = ram_rd_data;
            end
         end
         S_DECIDE: begin
            rsp_strobe_in = 1'b1;
            state_in      = S_IDLE;
            if (found_ff) begin
               ram_wr_en     = 1'b1;
               rsp_status_in = ST_ADDED;
               rsp_idx_in    = best_ff;
               rsp_load_in   = added_load;
            end else if (dur_ff == '0) begin
               rsp_status_in = ST_UNPLACED;
               rsp_idx_in    = '0;
               rsp_load_in   = '0;
            end else if (count_ff == CNT_W'(MAX_BINS)) begin
               rsp_status_in = ST_REJECTED;
               rsp_idx_in    = '0;
               rsp_load_in   = '0;
            end else begin
               ram_wr_en     = 1'b1;
               ram_wr_addr   = count_ff[IDX_W-1:0];
               ram_wr_data   = LOAD_W'(dur_ff);
               count_in      = count_ff + CNT_W'(1);
               rsp_status_in = ST_OPENED;
               rsp_idx_in    = count_ff[IDX_W-1:0];
               rsp_load_in   = LOAD_W'(dur_ff);
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         chk_vld_ff    <= 1'b0;
         found_ff      <= 1'b0;
         cap_ff        <= CAPACITY_RESET;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         chk_vld_ff    <= chk_vld_in;
         found_ff      <= found_in;
         cap_ff        <= cap_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      issue_ff      <= issue_in;
      chk_idx_ff    <= chk_idx_in;
      best_ff       <= best_in;
      best_load_ff  <= best_load_in;
      dur_ff        <= dur_in;
      rsp_status_ff <= rsp_status_in;
      rsp_idx_ff    <= rsp_idx_in;
      rsp_load_ff   <= rsp_load_in;
   end

   // Response beat; wide bin counts are reported masked to the field widths
   assign rsp_strobe    = rsp_strobe_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_bin_index = BIN_IDX_W'(rsp_idx_ff);
   assign rsp_bin_load  = rsp_load_ff;
   assign rsp_bins_used = BINS_USED_W'(count_ff);

   // Checks
   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("response strobe while busy");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_BINS))
      else $error("open bin count beyond MAX_BINS");

   a_write_decide: assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |-> (state_ff == S_DECIDE))
      else $error("load RAM written outside decision step");

   a_check_in_scan: assert property (@(posedge clock) disable iff (reset)
      chk_vld_ff |-> (state_ff == S_SCAN))
      else $error("pending compare outside scan");

   a_place_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_cmd == CMD_PLACE)) |=> busy)
      else $error("place command did not start a scan");

endmodule
